@@ rtl/assert_macros.svh @@
// Assertion macros used by the decoder controller, dgd_ctrl.
// Active in simulation, empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define DGD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// next-cycle implication
`define DGD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`else

`define DGD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define DGD_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ rtl/dgd_pkg.sv @@
// Shared constants and types of the detection grid decoder.
// Used by dgd_ctrl, dgd_datapath and detection_grid_decoder.
`default_nettype none

package dgd_pkg;

  localparam int NUM_CLASSES = 25;

  localparam int CH_W       = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 54;
  localparam int DQ_SEL_W   = 3;

  localparam logic [CH_W-1:0] OBJ_CH         = CH_W'(4);
  localparam logic [CH_W-1:0] FIRST_CLASS_CH = CH_W'(5);
  localparam logic [CH_W-1:0] LAST_CH        = CH_W'(4 + NUM_CLASSES);

  localparam logic [CFG_IDX_W-1:0] REG_ZERO_POINT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUANT_SCALE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_Q  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_PX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_TABLE = 3'd4;

  localparam logic signed [7:0] ZERO_POINT_RST   = 8'sd0;
  localparam logic [15:0]       QUANT_SCALE_RST  = 16'd256;
  localparam logic signed [7:0] THRESHOLD_Q_RST  = 8'sd0;
  localparam logic [6:0]        STRIDE_PX_RST    = 7'd8;
  localparam logic [53:0]       ANCHOR_TABLE_RST = 54'd811512331508234;

  // dequantizer step: 0..3 box, then objectness, then best probability
  localparam logic [DQ_SEL_W-1:0] DQ_OBJ  = 3'd4;
  localparam logic [DQ_SEL_W-1:0] DQ_PROB = 3'd5;
  localparam logic [DQ_SEL_W-1:0] DQ_LAST = 3'd5;

  typedef struct packed {
    logic                accept;
    logic                deq_en;
    logic [DQ_SEL_W-1:0] deq_sel;
    logic                sqr_en;
    logic                mul_en;
    logic                load_out;
  } dgd_cmd_t;

  typedef struct packed {
    logic emit;
  } dgd_status_t;

endpackage

`default_nettype wire

@@ rtl/dgd_ctrl.sv @@
// Controller of the detection grid decoder: handshakes and decode sequencing.
// Depends on dgd_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module dgd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  dgd_pkg::dgd_status_t status,
  output dgd_pkg::dgd_cmd_t    cmd
);
  import dgd_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DEQ  = 5'b00010,
    ST_SQR  = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t              state, state_next;
  logic [DQ_SEL_W-1:0] step, step_next;
  logic                accept;
  logic                load_out;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign load_out = (state == ST_OUT) && (!out_valid || out_ready);

  always_comb begin
    cmd.accept   = accept;
    cmd.deq_en   = (state == ST_DEQ);
    cmd.deq_sel  = step;
    cmd.sqr_en   = (state == ST_SQR);
    cmd.mul_en   = (state == ST_MUL);
    cmd.load_out = load_out;
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      ST_IDLE: begin
        if (accept && status.emit) begin
          state_next = ST_DEQ;
          step_next  = '0;
        end
      end
      ST_DEQ: begin
        if (step == DQ_LAST) begin
          state_next = ST_SQR;
          step_next  = '0;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ST_SQR: state_next = ST_MUL;
      ST_MUL: state_next = ST_OUT;
      ST_OUT: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
        step_next  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `DGD_ASSERT_NEXT(a_emit_starts_decode, clk, rst, accept && status.emit, state == ST_DEQ)
  `DGD_ASSERT_NEXT(a_deq_done, clk, rst, state == ST_DEQ && step == DQ_LAST, state == ST_SQR)
  `DGD_ASSERT_NEXT(a_result_held, clk, rst, state == ST_OUT && out_valid && !out_ready, state == ST_OUT)
  `DGD_ASSERT_IMP(a_no_accept_busy, clk, rst, state != ST_IDLE, !cmd.accept)
  `DGD_ASSERT_NEXT(a_load_sets_valid, clk, rst, load_out, out_valid)

endmodule

`default_nettype wire

@@ rtl/dgd_datapath.sv @@
// Datapath of the detection grid decoder: config registers, per-cell state,
// dequantizer, box and score arithmetic, result register. Depends on dgd_pkg.
`default_nettype none

module dgd_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [dgd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dgd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic signed [7:0]              value,
  input  logic [dgd_pkg::CH_W-1:0]       channel,
  input  logic [7:0]                     grid_col,
  input  logic [7:0]                     grid_row,
  input  logic [1:0]                     anchor_slot,
  input  dgd_pkg::dgd_cmd_t              cmd,
  output dgd_pkg::dgd_status_t           status,
  output logic signed [16:0]             box_left,
  output logic signed [16:0]             box_top,
  output logic [15:0]                    box_width,
  output logic [15:0]                    box_height,
  output logic [15:0]                    score,
  output logic [4:0]                     class_index
);
  import dgd_pkg::*;

  logic signed [7:0] zero_point;
  logic [15:0]       quant_scale;
  logic signed [7:0] threshold_q;
  logic [6:0]        stride_px;
  logic [53:0]       anchor_table;

  logic signed [7:0] box_raw [4];
  logic signed [7:0] obj_raw;
  logic signed [7:0] best_prob;
  logic [4:0]        best_class;
  logic [7:0]        col_r, row_r;
  logic [1:0]        slot_r;

  logic              is_class, is_last, take;
  logic signed [7:0] best_next;

  logic signed [7:0]  deq_q;
  logic signed [8:0]  deq_diff;
  logic signed [25:0] deq_prod;
  logic signed [24:0] dq [6];

  logic [23:0]        mag_w, mag_h;
  logic [47:0]        sq_w, sq_h;
  logic signed [27:0] cxb, cyb, cxb_next, cyb_next;
  logic signed [49:0] sprod;

  logic [17:0]        pair;
  logic [8:0]         aw, ah;
  logic [56:0]        wa, ha;
  logic signed [35:0] cx, cy;

  logic signed [63:0] left_full, top_full, left_q, top_q;
  logic [57:0]        w_rnd, h_rnd;
  logic [49:0]        s_rnd;
  logic signed [16:0] left_sat, top_sat;
  logic [15:0]        w_sat, h_sat, s_sat;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_point   <= ZERO_POINT_RST;
      quant_scale  <= QUANT_SCALE_RST;
      threshold_q  <= THRESHOLD_Q_RST;
      stride_px    <= STRIDE_PX_RST;
      anchor_table <= ANCHOR_TABLE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ZERO_POINT:   zero_point   <= cfg_data[7:0];
        REG_QUANT_SCALE:  quant_scale  <= cfg_data[15:0];
        REG_THRESHOLD_Q:  threshold_q  <= cfg_data[7:0];
        REG_STRIDE_PX:    stride_px    <= cfg_data[6:0];
        REG_ANCHOR_TABLE: anchor_table <= cfg_data[53:0];
        default: ;
      endcase
    end
  end

  // item intake and decision
  assign is_class  = (channel >= FIRST_CLASS_CH) && (channel <= LAST_CH);
  assign is_last   = (channel == LAST_CH);
  assign take      = (channel == FIRST_CLASS_CH) || (is_class && (value > best_prob));
  assign best_next = take ? value : best_prob;

  always_comb begin
    status.emit = is_last && (obj_raw >= threshold_q) && (best_next > threshold_q);
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (channel < OBJ_CH) begin
        box_raw[channel[1:0]] <= value;
      end
      if (channel == OBJ_CH) begin
        obj_raw <= value;
      end
      if (take) begin
        best_prob <= value;
      end
      if (is_last) begin
        col_r  <= grid_col;
        row_r  <= grid_row;
        slot_r <= anchor_slot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_class <= '0;
    end else if (cmd.accept && take) begin
      best_class <= 5'(channel - FIRST_CLASS_CH);
    end
  end

  // dequantize one value per step
  always_comb begin
    case (cmd.deq_sel)
      DQ_OBJ:  deq_q = obj_raw;
      DQ_PROB: deq_q = best_prob;
      default: deq_q = box_raw[cmd.deq_sel[1:0]];
    endcase
  end

  assign deq_diff = {deq_q[7], deq_q} - {zero_point[7], zero_point};
  assign deq_prod = deq_diff * $signed({1'b0, quant_scale});

  always_ff @(posedge clk) begin
    if (cmd.deq_en) begin
      dq[cmd.deq_sel] <= deq_prod[24:0];
    end
  end

  // squares, center bases, score product
  assign mag_w = 24'(dq[2][24] ? -dq[2] : dq[2]);
  assign mag_h = 24'(dq[3][24] ? -dq[3] : dq[3]);

  assign cxb_next = $signed({{2{dq[0][24]}}, dq[0], 1'b0}) - 28'sd32768
                  + $signed({4'b0, col_r, 16'b0});
  assign cyb_next = $signed({{2{dq[1][24]}}, dq[1], 1'b0}) - 28'sd32768
                  + $signed({4'b0, row_r, 16'b0});

  always_ff @(posedge clk) begin
    if (cmd.sqr_en) begin
      sq_w  <= mag_w * mag_w;
      sq_h  <= mag_h * mag_h;
      cxb   <= cxb_next;
      cyb   <= cyb_next;
      sprod <= dq[4] * dq[5];
    end
  end

  // anchor scaling and stride
  always_comb begin
    case (slot_r)
      2'd0:    pair = anchor_table[17:0];
      2'd1:    pair = anchor_table[35:18];
      default: pair = anchor_table[53:36];
    endcase
  end

  assign aw = pair[8:0];
  assign ah = pair[17:9];

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      wa <= sq_w * aw;
      ha <= sq_h * ah;
      cx <= cxb * $signed({1'b0, stride_px});
      cy <= cyb * $signed({1'b0, stride_px});
    end
  end

  // round to Q12.4 / Q0.16 and saturate
  assign left_full = $signed({{12{cx[35]}}, cx, 16'b0}) - $signed({6'b0, wa, 1'b0})
                   + 64'sd134217728;
  assign top_full  = $signed({{12{cy[35]}}, cy, 16'b0}) - $signed({6'b0, ha, 1'b0})
                   + 64'sd134217728;
  assign left_q    = left_full >>> 28;
  assign top_q     = top_full >>> 28;

  always_comb begin
    if (left_q < -64'sd65536) begin
      left_sat = -17'sd65536;
    end else if (left_q > 64'sd65535) begin
      left_sat = 17'sd65535;
    end else begin
      left_sat = left_q[16:0];
    end
    if (top_q < -64'sd65536) begin
      top_sat = -17'sd65536;
    end else if (top_q > 64'sd65535) begin
      top_sat = 17'sd65535;
    end else begin
      top_sat = top_q[16:0];
    end
  end

  assign w_rnd = {1'b0, wa} + (58'd1 << 25);
  assign h_rnd = {1'b0, ha} + (58'd1 << 25);
  assign w_sat = (|w_rnd[57:42]) ? 16'hFFFF : w_rnd[41:26];
  assign h_sat = (|h_rnd[57:42]) ? 16'hFFFF : h_rnd[41:26];

  assign s_rnd = {1'b0, sprod[48:0]} + 50'd32768;

  always_comb begin
    if (sprod[49] || (sprod == '0)) begin
      s_sat = '0;
    end else if (|s_rnd[49:32]) begin
      s_sat = 16'hFFFF;
    end else begin
      s_sat = s_rnd[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      box_left    <= left_sat;
      box_top     <= top_sat;
      box_width   <= w_sat;
      box_height  <= h_sat;
      score       <= s_sat;
      class_index <= best_class;
    end
  end

endmodule

`default_nettype wire

@@ rtl/detection_grid_decoder.sv @@
// Detection grid decoder: one int8 channel item per cycle; per cell, at most one detection.
// After its last channel, a cell that yields a detection busies the block for 6 dequantizer
// steps, square, multiply and output load, which waits while the last result is not taken.
// Throughput: 1 item/cycle while decoding is idle; the single dequantizer is shared.
// Reset (rst, synchronous): config registers to defaults, best class cleared, no result.
// Depends on dgd_pkg, dgd_ctrl, dgd_datapath.
`default_nettype none

module detection_grid_decoder (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [dgd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dgd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [7:0]              value,
  input  logic [dgd_pkg::CH_W-1:0]       channel,
  input  logic [7:0]                     grid_col,
  input  logic [7:0]                     grid_row,
  input  logic [1:0]                     anchor_slot,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [16:0]             box_left,
  output logic signed [16:0]             box_top,
  output logic [15:0]                    box_width,
  output logic [15:0]                    box_height,
  output logic [15:0]                    score,
  output logic [4:0]                     class_index
);
  import dgd_pkg::*;

  dgd_cmd_t    cmd;
  dgd_status_t status;

  dgd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  dgd_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .value       (value),
    .channel     (channel),
    .grid_col    (grid_col),
    .grid_row    (grid_row),
    .anchor_slot (anchor_slot),
    .cmd         (cmd),
    .status      (status),
    .box_left    (box_left),
    .box_top     (box_top),
    .box_width   (box_width),
    .box_height  (box_height),
    .score       (score),
    .class_index (class_index)
  );

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for detection_grid_decoder: a directed table of channel items, then
// random cells under changing register settings, each result checked against a local model.
// Depends on dgd_pkg and the decoder RTL only.

module tb;
  import dgd_pkg::*;

  localparam int CLK_PERIOD      = 12;
  localparam int LIMIT_CYCLES    = 300000;
  localparam int ITEM_TARGET     = 1350;
  localparam int DET_TARGET      = 48;
  localparam int MAX_PHASES      = 40;
  localparam int CELLS_PER_PHASE = 6;
  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_CYCLES    = 12;
  localparam int END_WAIT        = 4000;
  localparam int IDLE_PCT        = 23;
  localparam int LAST_SLOT       = 2;

  localparam logic [CH_W-1:0] BOX_X_CH   = CH_W'(0);
  localparam logic [CH_W-1:0] BOX_Y_CH   = CH_W'(1);
  localparam logic [CH_W-1:0] BOX_W_CH   = CH_W'(2);
  localparam logic [CH_W-1:0] BOX_H_CH   = CH_W'(3);
  localparam logic [CH_W-1:0] IGNORED_CH = CH_W'(LAST_CH + 2);

  typedef struct packed {
    logic signed [7:0] value;
    logic [CH_W-1:0]   channel;
    logic [7:0]        col;
    logic [7:0]        row;
    logic [1:0]        slot;
  } chan_item_t;

  typedef struct packed {
    logic signed [16:0] left;
    logic signed [16:0] top;
    logic [15:0]        width;
    logic [15:0]        height;
    logic [15:0]        score;
    logic [4:0]         cls;
  } detection_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_TYPED, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    chan_item_t            it;
    logic [CFG_IDX_W-1:0]  ridx;
    logic [CFG_DATA_W-1:0] rval;
    detection_t            det;
  } plan_row_t;

  localparam plan_row_t PLAN [31] = '{
    '{ROW_ITEM, '{8'sd0, BOX_X_CH, 8'd0, 8'd0, 2'd0}, '0, '0, '0},
    '{ROW_ITEM, '{8'sd0, BOX_Y_CH, 8'd0, 8'd0, 2'd0}, '0, '0, '0},
    '{ROW_ITEM, '{8'sd0, BOX_W_CH, 8'd0, 8'd0, 2'd0}, '0, '0, '0},
    '{ROW_ITEM, '{8'sd0, BOX_H_CH, 8'd0, 8'd0, 2'd0}, '0, '0, '0},
    '{ROW_ITEM, '{8'sd127, OBJ_CH, 8'd0, 8'd0, 2'd0}, '0, '0, '0},
    '{ROW_ITEM, '{8'sd100, FIRST_CLASS_CH, 8'd0, 8'd0, 2'd0}, '0, '0, '0},
    '{ROW_TYPED, '{8'sh80, LAST_CH, 8'd0, 8'd0, 2'd0}, '0, '0,
      '{-17'sd64, -17'sd64, 16'd0, 16'd0, 16'd12700, 5'd0}},
    '{ROW_ITEM, '{8'sh55, IGNORED_CH, 8'hAA, 8'h55, 2'd1}, '0, '0, '0},
    '{ROW_ITEM, '{8'sd10, FIRST_CLASS_CH, 8'd255, 8'd255, 2'd3}, '0, '0, '0},
    '{ROW_ITEM, '{8'sd90, FIRST_CLASS_CH + 5'd1, 8'd255, 8'd255, 2'd3}, '0, '0, '0},
    '{ROW_ITEM, '{8'sd90, FIRST_CLASS_CH + 5'd2, 8'd255, 8'd255, 2'd3}, '0, '0, '0},
    '{ROW_ITEM, '{8'sd90, LAST_CH, 8'd255, 8'd255, 2'd3}, '0, '0, '0},
    '{ROW_ITEM, '{8'shFF, OBJ_CH, 8'd0, 8'd0, 2'd0}, '0, '0, '0},
    '{ROW_ITEM, '{8'sd5, LAST_CH, 8'd0, 8'd0, 2'd0}, '0, '0, '0},
    '{ROW_ITEM, '{8'sd0, OBJ_CH, 8'd0, 8'd0, 2'd0}, '0, '0, '0},
    '{ROW_ITEM, '{8'sd0, FIRST_CLASS_CH, 8'd0, 8'd0, 2'd0}, '0, '0, '0},
    '{ROW_ITEM, '{8'sd0, LAST_CH, 8'd0, 8'd0, 2'd0}, '0, '0, '0},
    '{ROW_TYPED, '{8'sd1, LAST_CH, 8'd0, 8'd0, 2'd0}, '0, '0,
      '{-17'sd64, -17'sd64, 16'd0, 16'd0, 16'd0, 5'(NUM_CLASSES - 1)}},
    '{ROW_REG, '0, REG_THRESHOLD_Q, 54'h80, '0},
    '{ROW_ITEM, '{-8'sd100, OBJ_CH, 8'd0, 8'd0, 2'd0}, '0, '0, '0},
    '{ROW_ITEM, '{8'sd50, FIRST_CLASS_CH, 8'd0, 8'd0, 2'd0}, '0, '0, '0},
    '{ROW_ITEM, '{8'sd50, LAST_CH, 8'd0, 8'd0, 2'd0}, '0, '0, '0},
    '{ROW_REG, '0, REG_ZERO_POINT, 54'h80, '0},
    '{ROW_REG, '0, REG_QUANT_SCALE, 54'hFFFF, '0},
    '{ROW_REG, '0, REG_STRIDE_PX, 54'd64, '0},
    '{ROW_REG, '0, REG_ANCHOR_TABLE, {54{1'b1}}, '0},
    '{ROW_ITEM, '{8'sh80, BOX_X_CH, 8'd255, 8'd255, 2'd1}, '0, '0, '0},
    '{ROW_ITEM, '{8'sd127, BOX_W_CH, 8'd255, 8'd255, 2'd1}, '0, '0, '0},
    '{ROW_ITEM, '{8'sd127, LAST_CH, 8'd255, 8'd255, 2'd1}, '0, '0, '0},
    '{ROW_REG, '0, REG_STRIDE_PX, 54'd0, '0},
    '{ROW_ITEM, '{8'sd127, LAST_CH, 8'd128, 8'd1, 2'd2}, '0, '0, '0}
  };

  logic                  clk         = 1'b0;
  logic                  rst         = 1'b1;
  logic                  cfg_write   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  logic signed [7:0]     value       = '0;
  logic [CH_W-1:0]       channel     = '0;
  logic [7:0]            grid_col    = '0;
  logic [7:0]            grid_row    = '0;
  logic [1:0]            anchor_slot = '0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  logic signed [16:0]    box_left;
  logic signed [16:0]    box_top;
  logic [15:0]           box_width;
  logic [15:0]           box_height;
  logic [15:0]           score;
  logic [4:0]            class_index;

  detection_grid_decoder dut (.*);

  // model state and register copies
  logic signed [7:0] zp_m      = ZERO_POINT_RST;
  logic [15:0]       scale_m   = QUANT_SCALE_RST;
  logic signed [7:0] thr_m     = THRESHOLD_Q_RST;
  logic [6:0]        stride_m  = STRIDE_PX_RST;
  logic [53:0]       anchors_m = ANCHOR_TABLE_RST;
  logic signed [7:0] box_q [4] = '{default: '0};
  logic signed [7:0] obj_q     = '0;
  logic signed [7:0] best_q    = '0;
  logic [4:0]        best_cls  = '0;

  detection_t pending_dets [$];
  int         error_count = 0;
  int         item_count  = 0;
  int         det_count   = 0;
  bit         calm        = 1'b0;
  bit         hold_go     = 1'b0;
  bit         hold_done   = 1'b0;

  initial forever #(CLK_PERIOD / 2) clk = ~clk;

  function automatic longint dequant(logic signed [7:0] q);
    return (longint'(q) - longint'(zp_m)) * longint'(scale_m);
  endfunction

  function automatic longint to_q4(longint x);
    return (x + (longint'(1) <<< 27)) >>> 28;
  endfunction

  function automatic longint clamp(longint x, longint lo, longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  task automatic decode_step(input chan_item_t it, output bit emits, output detection_t det);
    int     s;
    longint dx, dy, dw, dh, aw, ah, cx, cy, w32, h32, prod, sc;
    emits = 1'b0;
    det   = '0;
    if (it.channel > LAST_CH) return;
    if (it.channel < OBJ_CH) begin
      box_q[it.channel[1:0]] = it.value;
    end else if (it.channel == OBJ_CH) begin
      obj_q = it.value;
    end else if (it.channel == FIRST_CLASS_CH) begin
      best_q   = it.value;
      best_cls = '0;
    end else if (it.value > best_q) begin
      best_q   = it.value;
      best_cls = 5'(it.channel - FIRST_CLASS_CH);
    end
    if (it.channel != LAST_CH) return;
    if (!(obj_q >= thr_m && best_q > thr_m)) return;
    emits = 1'b1;
    s   = (int'(it.slot) > LAST_SLOT) ? LAST_SLOT : int'(it.slot);
    aw  = longint'(anchors_m[18*s +: 9]);
    ah  = longint'(anchors_m[18*s+9 +: 9]);
    dx  = dequant(box_q[BOX_X_CH[1:0]]);
    dy  = dequant(box_q[BOX_Y_CH[1:0]]);
    dw  = dequant(box_q[BOX_W_CH[1:0]]);
    dh  = dequant(box_q[BOX_H_CH[1:0]]);
    cx  = (2 * dx - 32768 + longint'(it.col) * 65536) * longint'(stride_m);
    cy  = (2 * dy - 32768 + longint'(it.row) * 65536) * longint'(stride_m);
    w32 = 4 * dw * dw * aw;
    h32 = 4 * dh * dh * ah;
    det.left   = 17'(clamp(to_q4(cx * 65536 - w32 / 2), -65536, 65535));
    det.top    = 17'(clamp(to_q4(cy * 65536 - h32 / 2), -65536, 65535));
    det.width  = 16'(clamp(to_q4(w32), 0, 65535));
    det.height = 16'(clamp(to_q4(h32), 0, 65535));
    prod = dequant(obj_q) * dequant(best_q);
    sc   = (prod <= 0) ? 0 : ((prod + 32768) >>> 16);
    det.score = 16'(clamp(sc, 0, 65535));
    det.cls   = best_cls;
  endtask

  task automatic flag_mismatch(input string msg);
    error_count++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic expect_det(input detection_t d);
    pending_dets.insert(pending_dets.size(), d);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_ZERO_POINT:   zp_m      = data[7:0];
      REG_QUANT_SCALE:  scale_m   = data[15:0];
      REG_THRESHOLD_Q:  thr_m     = data[7:0];
      REG_STRIDE_PX:    stride_m  = data[6:0];
      REG_ANCHOR_TABLE: anchors_m = data[53:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // drop valid, wait for every expected detection, then let the block go quiet
  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_dets.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_item(input chan_item_t it, input bit typed, input detection_t fixed);
    bit         emits;
    detection_t det;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    value       <= it.value;
    channel     <= it.channel;
    grid_col    <= it.col;
    grid_row    <= it.row;
    anchor_slot <= it.slot;
    do @(posedge clk); while (!in_ready);
    decode_step(it, emits, det);
    if (typed) expect_det(fixed);
    else if (emits) expect_det(det);
    if (typed || emits) det_count++;
    if (it.channel <= LAST_CH) item_count++;
    @(negedge clk);
  endtask

  function automatic logic signed [7:0] cell_value();
    case ($urandom_range(0, 9))
      0:       return 8'sh80;
      1:       return 8'sd127;
      2:       return thr_m;
      3:       return thr_m + 8'sd1;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic chan_item_t any_item(int ch_lo, int ch_hi);
    chan_item_t it;
    it.value   = cell_value();
    it.channel = CH_W'($urandom_range(ch_lo, ch_hi));
    it.col     = 8'($urandom);
    it.row     = 8'($urandom);
    it.slot    = 2'($urandom);
    return it;
  endfunction

  task automatic send_cell();
    int         shape;
    chan_item_t it;
    shape = $urandom_range(0, 99);
    it    = any_item(0, int'(LAST_CH));
    if (shape < 75) begin
      for (int c = 0; c <= int'(LAST_CH); c++) begin
        if ($urandom_range(0, 39) == 0)
          send_item(any_item(int'(LAST_CH) + 1, int'(IGNORED_CH)), 1'b0, '0);
        it.channel = CH_W'(c);
        it.value   = cell_value();
        send_item(it, 1'b0, '0);
      end
    end else if (shape < 92) begin
      repeat ($urandom_range(1, 12)) send_item(any_item(0, int'(LAST_CH)), 1'b0, '0);
      if ($urandom_range(0, 1) == 1)
        send_item(any_item(int'(LAST_CH), int'(LAST_CH)), 1'b0, '0);
    end else begin
      repeat ($urandom_range(1, 3))
        send_item(any_item(int'(LAST_CH) + 1, int'(IGNORED_CH)), 1'b0, '0);
    end
  endtask

  function automatic logic [53:0] pick_setting(int sel, logic [53:0] lo, logic [53:0] hi,
                                               logic [53:0] dflt, logic [53:0] rnd);
    case (sel)
      0:       return lo;
      1:       return hi;
      2:       return dflt;
      default: return rnd;
    endcase
  endfunction

  task automatic configure_phase(input int p);
    int          sel;
    logic [53:0] v;
    for (int r = 0; r <= int'(REG_ANCHOR_TABLE); r++) begin
      sel = (p < 4) ? p : $urandom_range(0, 3);
      case (CFG_IDX_W'(r))
        REG_ZERO_POINT:
          v = pick_setting(sel, 54'h80, 54'h7F, {46'b0, ZERO_POINT_RST},
                           54'($urandom_range(0, 255)));
        REG_QUANT_SCALE:
          v = pick_setting(sel, 54'd1, 54'hFFFF, {38'b0, QUANT_SCALE_RST},
                           54'($urandom_range(1, 65535)));
        REG_THRESHOLD_Q:
          v = pick_setting(sel, 54'h80, 54'h7F, {46'b0, THRESHOLD_Q_RST},
                           54'($urandom_range(0, 255)));
        REG_STRIDE_PX:
          v = pick_setting(sel, 54'd1, 54'd64, {47'b0, STRIDE_PX_RST},
                           54'($urandom_range(0, 64)));
        default:
          v = pick_setting(sel, 54'd0, {54{1'b1}}, ANCHOR_TABLE_RST,
                           54'({$urandom, $urandom}));
      endcase
      write_reg(CFG_IDX_W'(r), v);
    end
  endtask

  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_go && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin : watch_results
    detection_t got;
    detection_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{box_left, box_top, box_width, box_height, score, class_index};
      if (pending_dets.size() == 0) begin
        flag_mismatch($sformatf("unexpected detection, class %0d", got.cls));
      end else begin
        want = pending_dets.pop_front();
        if (got.left !== want.left)
          flag_mismatch($sformatf("box_left %0d, want %0d", got.left, want.left));
        if (got.top !== want.top)
          flag_mismatch($sformatf("box_top %0d, want %0d", got.top, want.top));
        if (got.width !== want.width)
          flag_mismatch($sformatf("box_width %0d, want %0d", got.width, want.width));
        if (got.height !== want.height)
          flag_mismatch($sformatf("box_height %0d, want %0d", got.height, want.height));
        if (got.score !== want.score)
          flag_mismatch($sformatf("score %0d, want %0d", got.score, want.score));
        if (got.cls !== want.cls)
          flag_mismatch($sformatf("class_index %0d, want %0d", got.cls, want.cls));
      end
    end
  end

  initial begin : stimulus
    int phase;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (int i = 0; i < $size(PLAN); i++) begin
      if (PLAN[i].kind == ROW_REG) begin
        drain_block();
        write_reg(PLAN[i].ridx, PLAN[i].rval);
      end else begin
        send_item(PLAN[i].it, PLAN[i].kind == ROW_TYPED, PLAN[i].det);
      end
    end
    phase = 0;
    while ((item_count < ITEM_TARGET || det_count < DET_TARGET) && phase < MAX_PHASES) begin
      drain_block();
      configure_phase(phase);
      calm = (phase == 3);
      if (phase == 2) hold_go = 1'b1;
      repeat (CELLS_PER_PHASE) send_cell();
      phase++;
    end
    in_valid <= 1'b0;
    for (int k = 0; k < END_WAIT && pending_dets.size() != 0; k++) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending_dets.size() != 0)
      flag_mismatch($sformatf("%0d detections never came out", pending_dets.size()));
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("TB_ERROR");
    $finish;
  end

endmodule
